/* src/fbpwm_pkg.sv */
package fbpwm_pkg;

  localparam int CLK_W  = 20;
  localparam int FREQ_W = 16;
  localparam int TOP_W  = 16;
  localparam int LVL_W  = 8;
  localparam int PTR_W  = 8;
  localparam int DIV_STEPS = CLK_W;
  localparam int STEP_W = $clog2(DIV_STEPS);

  localparam logic [CLK_W-1:0]  DEFAULT_CLOCK = CLK_W'(500000);
  localparam logic [FREQ_W-1:0] DEFAULT_FREQ  = FREQ_W'(1760);
  localparam logic [TOP_W-1:0]  DEFAULT_TOP   = TOP_W'(283);

  // action codes
  localparam logic [1:0] ACT_IDLE  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_BYTE  = 2'd2;

  // device register map
  localparam logic [2:0] REG_RED     = 3'd0;
  localparam logic [2:0] REG_GREEN   = 3'd1;
  localparam logic [2:0] REG_BLUE    = 3'd2;
  localparam logic [2:0] REG_VIBE    = 3'd3;
  localparam logic [2:0] REG_SPEAKER = 3'd4;
  localparam logic [2:0] REG_FREQ_HI = 3'd5;
  localparam logic [2:0] REG_FREQ_LO = 3'd6;
  localparam logic [PTR_W-1:0] REG_SLOTS = PTR_W'(7);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* src/feedback_register_pwm_tone_ctrl_unit.sv */
// feedback peripheral: rgb software pwm, vibration and speaker tone control
// input channel (in_valid / in_stall): one word per main-loop pass, carrying
//   action (idle tick, bus start, bus byte) and data_byte
// output channel (out_valid / out_stall): one result word per input word,
//   the three led pwm bits, vibe and speaker enables, tone top, compare and
//   the saturation flag
// cfg_we / cfg_data load the 20-bit tone clock rate; it takes effect at the
//   next register write
// an idle tick, a start, a pointer byte or a byte past the last register
//   gives its result in the cycle after acceptance, and such words are
//   taken one per cycle while the output register is free
// a byte that writes a device register starts a restoring divider that
//   produces one quotient bit per cycle; the top is then updated from the
//   quotient, the result is published once the output register is free,
//   and only then is the next word taken
// reset: no result word, levels and enables off, tone frequency 1760, clock rate 500000, top 283
// a stalled receiver holds the result word in the output register; one more
//   input word is taken only if it will find the output register free
module feedback_register_pwm_tone_ctrl_unit
  import fbpwm_pkg::*;
#(
  parameter int PWM_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CLK_W-1:0]    cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          action,
  input  logic [7:0]          data_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                red_on,
  output logic                green_on,
  output logic                blue_on,
  output logic                vibe_on,
  output logic                speaker_on,
  output logic [TOP_W-1:0]    tone_top,
  output logic [TOP_W-2:0]    tone_compare,
  output logic                tone_saturated
);

  localparam int CMP_W = (PWM_BITS > LVL_W) ? PWM_BITS : LVL_W;

  state_t state, state_next;

  logic [CLK_W-1:0]    clock_rate;
  logic [PWM_BITS-1:0] pwm_count;
  logic [LVL_W-1:0]    level_r, level_g, level_b;
  logic [LVL_W-1:0]    level_r_next, level_g_next, level_b_next;
  logic                vibe_en, vibe_en_next;
  logic                spk_en, spk_en_next;
  logic [FREQ_W-1:0]   freq, freq_next;
  logic [TOP_W-1:0]    top;
  logic                ovf;
  logic [PTR_W-1:0]    ptr, ptr_next;
  logic [PTR_W-1:0]    nbytes, nbytes_next;
  logic [2:0]          lit_pending;

  logic                accept;
  logic                out_free;
  logic                is_write;
  logic                publish;
  logic [2:0]          lit;
  logic [2:0]          lit_pub;

  div_stat_t           div_stat;
  logic [CLK_W-1:0]    quotient;
  logic [TOP_W-1:0]    top_new;
  logic                ovf_new;

  assign out_free = !out_valid || !out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_write = (action == ACT_BYTE) && (nbytes != '0) && (ptr < REG_SLOTS);

  assign lit[0] = CMP_W'(pwm_count) < CMP_W'(level_r);
  assign lit[1] = CMP_W'(pwm_count) < CMP_W'(level_g);
  assign lit[2] = CMP_W'(pwm_count) < CMP_W'(level_b);

  // bus start and byte handling
  always_comb begin
    level_r_next = level_r;
    level_g_next = level_g;
    level_b_next = level_b;
    vibe_en_next = vibe_en;
    spk_en_next  = spk_en;
    freq_next    = freq;
    ptr_next     = ptr;
    nbytes_next  = nbytes;
    if (action == ACT_START) begin
      nbytes_next = '0;
    end else if (action == ACT_BYTE) begin
      nbytes_next = nbytes + 1'b1;
      if (nbytes == '0) begin
        ptr_next = data_byte;
      end else if (ptr < REG_SLOTS) begin
        ptr_next = ptr + 1'b1;
        unique case (ptr[2:0])
          REG_RED:     level_r_next = data_byte;
          REG_GREEN:   level_g_next = data_byte;
          REG_BLUE:    level_b_next = data_byte;
          REG_VIBE:    vibe_en_next = data_byte != '0;
          REG_SPEAKER: spk_en_next  = data_byte != '0;
          REG_FREQ_HI: freq_next    = {data_byte, freq[7:0]};
          REG_FREQ_LO: freq_next    = {freq[FREQ_W-1:8], data_byte};
          default:     ;
        endcase
      end
    end
  end

  // a zero divisor yields an all-ones quotient, which saturates the top
  always_comb begin
    if (quotient[CLK_W-1:TOP_W] != '0) begin
      top_new = '1;
      ovf_new = 1'b1;
    end else if (quotient == '0) begin
      top_new = '0;
      ovf_new = 1'b0;
    end else begin
      top_new = quotient[TOP_W-1:0] - 1'b1;
      ovf_new = 1'b0;
    end
  end

  fbpwm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && is_write),
    .dividend (clock_rate),
    .divisor  (freq_next),
    .stat     (div_stat),
    .quotient (quotient)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept && is_write) state_next = ST_DIV;
      ST_DIV:  if (div_stat.done) state_next = ST_HOLD;
      ST_HOLD: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    publish  = 1'b0;
    lit_pub  = lit;
    unique case (state)
      ST_IDLE: begin
        in_stall = !out_free;
        publish  = accept && !is_write;
      end
      ST_DIV: ;
      ST_HOLD: begin
        publish = out_free;
        lit_pub = lit_pending;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      clock_rate <= DEFAULT_CLOCK;
      pwm_count  <= '0;
      level_r    <= '0;
      level_g    <= '0;
      level_b    <= '0;
      vibe_en    <= 1'b0;
      spk_en     <= 1'b0;
      freq       <= DEFAULT_FREQ;
      top        <= DEFAULT_TOP;
      ovf        <= 1'b0;
      ptr        <= '0;
      nbytes     <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        clock_rate <= cfg_data;
      end
      if (accept) begin
        pwm_count <= pwm_count + 1'b1;
        level_r   <= level_r_next;
        level_g   <= level_g_next;
        level_b   <= level_b_next;
        vibe_en   <= vibe_en_next;
        spk_en    <= spk_en_next;
        freq      <= freq_next;
        ptr       <= ptr_next;
        nbytes    <= nbytes_next;
      end
      if (state == ST_DIV && div_stat.done) begin
        top <= top_new;
        ovf <= ovf_new;
      end
      out_valid <= publish || (out_valid && out_stall);
    end
  end

  // enables are unchanged by a non-write word and already updated for a held write
  always_ff @(posedge clk) begin
    if (accept) begin
      lit_pending <= lit;
    end
    if (publish) begin
      red_on         <= lit_pub[0];
      green_on       <= lit_pub[1];
      blue_on        <= lit_pub[2];
      vibe_on        <= vibe_en;
      speaker_on     <= spk_en;
      tone_top       <= top;
      tone_compare   <= top[TOP_W-1:1];
      tone_saturated <= ovf;
    end
  end

endmodule

/* src/fbpwm_div.sv */
module fbpwm_div
  import fbpwm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [CLK_W-1:0]  dividend,
  input  logic [FREQ_W-1:0] divisor,
  output div_stat_t         stat,
  output logic [CLK_W-1:0]  quotient
);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [FREQ_W-1:0] dvsr;
  logic [FREQ_W-1:0] rem;
  logic [CLK_W-1:0]  dq;

  logic [FREQ_W:0]   shifted;
  logic [FREQ_W:0]   diff;
  logic              ge;

  // one quotient bit per cycle, dividend bits shift out as quotient bits shift in
  assign shifted = {rem, dq[CLK_W-1]};
  assign diff    = shifted - {1'b0, dvsr};
  assign ge      = shifted >= {1'b0, dvsr};

  // done rises together with the last quotient bit shifting in
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (step == '0);
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(DIV_STEPS - 1);
      end else if (busy) begin
        if (step == '0) begin
          busy <= 1'b0;
        end
        step <= step - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvsr <= divisor;
      rem  <= '0;
      dq   <= dividend;
    end else if (busy) begin
      rem <= ge ? diff[FREQ_W-1:0] : shifted[FREQ_W-1:0];
      dq  <= {dq[CLK_W-2:0], ge};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = dq;

endmodule

/* src/fbpwm_chk.sv */
module fbpwm_chk
  import fbpwm_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic [1:0]       action,
  input logic             out_valid,
  input logic             out_stall,
  input logic [TOP_W-1:0] tone_top,
  input logic [TOP_W-2:0] tone_compare,
  input logic             tone_saturated
);

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word present after reset");

  // a stalled word stays
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(tone_top))
    else $error("stalled output word changed");

  // a word other than a bus byte taken into an empty output side answers next cycle
  a_fast: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (action != ACT_BYTE) && !out_valid |=> out_valid)
    else $error("non-write word did not produce a result");

  a_cmp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> tone_compare == tone_top[TOP_W-1:1])
    else $error("tone compare is not half of top");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && tone_saturated |-> tone_top == '1)
    else $error("saturated tone top is not full scale");

endmodule

bind feedback_register_pwm_tone_ctrl_unit fbpwm_chk u_chk (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .action         (action),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .tone_top       (tone_top),
  .tone_compare   (tone_compare),
  .tone_saturated (tone_saturated)
);

/* verif/feedback_register_pwm_tone_ctrl_unit_test.sv */
`timescale 1ns / 100ps
module feedback_register_pwm_tone_ctrl_unit_test;
  import fbpwm_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_WORDS = 1150;

  typedef struct packed {
    logic             red;
    logic             green;
    logic             blue;
    logic             vibe;
    logic             speaker;
    logic [TOP_W-1:0] top;
    logic [TOP_W-2:0] cmp;
    logic             sat;
  } tone_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [CLK_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       action = ACT_IDLE;
  logic [7:0]       data_byte = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             red_on;
  logic             green_on;
  logic             blue_on;
  logic             vibe_on;
  logic             speaker_on;
  logic [TOP_W-1:0] tone_top;
  logic [TOP_W-2:0] tone_compare;
  logic             tone_saturated;

  // peripheral state as the predictor sees it
  logic [CLK_W-1:0]  clock_rate = DEFAULT_CLOCK;
  logic [7:0]        pwm_phase = '0;
  logic [LVL_W-1:0]  led_level [3] = '{default: '0};
  logic              vibe_q = 1'b0;
  logic              speaker_q = 1'b0;
  logic [FREQ_W-1:0] freq_q = DEFAULT_FREQ;
  logic [TOP_W-1:0]  top_q = DEFAULT_TOP;
  logic              sat_q = 1'b0;
  logic [PTR_W-1:0]  reg_ptr = '0;
  logic [7:0]        bytes_after_start = '0;

  tone_result_t pending_results [$];
  int           mismatches = 0;
  int           words_sent = 0;
  int           cycle_count = 0;
  int           burst_left = 0;
  int           gap_max = 0;
  int           stall_pct = 0;
  int           stall_left = 0;

  feedback_register_pwm_tone_ctrl_unit i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .data_byte      (data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .red_on         (red_on),
    .green_on       (green_on),
    .blue_on        (blue_on),
    .vibe_on        (vibe_on),
    .speaker_on     (speaker_on),
    .tone_top       (tone_top),
    .tone_compare   (tone_compare),
    .tone_saturated (tone_saturated)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("feedback_register_pwm_tone_ctrl_unit_test: done, errors");
      $finish;
    end
  end

  // receiver back-pressure: stretches of fixed stall density, some with none
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_left <= $urandom_range(300, 50);
      case ($urandom_range(4))
        0, 1: stall_pct <= 0;
        2: stall_pct <= 25;
        3: stall_pct <= 50;
        default: stall_pct <= 85;
      endcase
    end else begin
      stall_left <= stall_left - 1;
    end
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // one pass of the peripheral: led bits use the levels held before the write
  function automatic tone_result_t step_peripheral(logic [1:0] act, logic [7:0] b);
    tone_result_t r;
    int unsigned  q;
    r.red   = pwm_phase < led_level[0];
    r.green = pwm_phase < led_level[1];
    r.blue  = pwm_phase < led_level[2];
    case (act)
      ACT_START: bytes_after_start = '0;
      ACT_BYTE: begin
        if (bytes_after_start == 0) begin
          reg_ptr = b;
        end else if (reg_ptr < REG_SLOTS) begin
          case (reg_ptr[2:0])
            REG_RED:     led_level[0] = b;
            REG_GREEN:   led_level[1] = b;
            REG_BLUE:    led_level[2] = b;
            REG_VIBE:    vibe_q = (b != 0);
            REG_SPEAKER: speaker_q = (b != 0);
            REG_FREQ_HI: freq_q[15:8] = b;
            REG_FREQ_LO: freq_q[7:0] = b;
            default: ;
          endcase
          if (freq_q == 0) begin
            top_q = '1;
            sat_q = 1'b1;
          end else begin
            q = clock_rate / freq_q;
            sat_q = q > 65535;
            if (q > 65535) top_q = '1;
            else if (q == 0) top_q = '0;
            else top_q = TOP_W'(q - 1);
          end
          reg_ptr = reg_ptr + 1'b1;
        end
        bytes_after_start = bytes_after_start + 1'b1;
      end
      default: ;
    endcase
    pwm_phase = pwm_phase + 1'b1;
    r.vibe    = vibe_q;
    r.speaker = speaker_q;
    r.top     = top_q;
    r.cmp     = top_q[TOP_W-1:1];
    r.sat     = sat_q;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : check_results
    tone_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word with nothing pending, tone_top", tone_top, 0);
      end else begin
        want = pending_results.pop_front();
        if (red_on != want.red) report_mismatch("red_on", red_on, want.red);
        if (green_on != want.green) report_mismatch("green_on", green_on, want.green);
        if (blue_on != want.blue) report_mismatch("blue_on", blue_on, want.blue);
        if (vibe_on != want.vibe) report_mismatch("vibe_on", vibe_on, want.vibe);
        if (speaker_on != want.speaker)
          report_mismatch("speaker_on", speaker_on, want.speaker);
        if (tone_top != want.top) report_mismatch("tone_top", tone_top, want.top);
        if (tone_compare != want.cmp)
          report_mismatch("tone_compare", tone_compare, want.cmp);
        if (tone_saturated != want.sat)
          report_mismatch("tone_saturated", tone_saturated, want.sat);
      end
    end
  end

  // sends one word, with a random gap at the start of each burst
  task automatic send_word(logic [1:0] act, logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(16, 1);
      gap = (gap_max == 0) ? 0 : $urandom_range(gap_max);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    action    <= act;
    data_byte <= b;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(step_peripheral(act, b));
    words_sent++;
  endtask

  // hold off until every result is back and the divider has settled
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_clock_rate(logic [CLK_W-1:0] v);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    clock_rate  = v;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_word(ACT_IDLE, 8'hFF);
    send_word(ACT_UNUSED, 8'hAA);
  endtask

  task automatic test_register_writes();
    send_word(ACT_START, 8'h00);
    send_word(ACT_BYTE, 8'(REG_RED));
    send_word(ACT_BYTE, 8'hFF);
    send_word(ACT_BYTE, 8'h80);
    send_word(ACT_BYTE, 8'h01);
    send_word(ACT_BYTE, 8'h06);
    send_word(ACT_BYTE, 8'hE0);
    // zero frequency saturates the top
    send_word(ACT_BYTE, 8'h00);
    send_word(ACT_BYTE, 8'h00);
    // pointer has run past the last register
    send_word(ACT_BYTE, 8'h55);
  endtask

  task automatic test_pointer_cases();
    send_word(ACT_START, 8'h00);
    send_word(ACT_BYTE, 8'hFF);
    send_word(ACT_BYTE, 8'h12);
    send_word(ACT_START, 8'h00);
    send_word(ACT_BYTE, 8'(REG_VIBE));
    send_word(ACT_BYTE, 8'h00);
  endtask

  task automatic test_clock_rate_extremes();
    // clock below frequency gives a zero quotient
    write_clock_rate(CLK_W'(1));
    send_word(ACT_START, 8'h00);
    send_word(ACT_BYTE, 8'(REG_FREQ_LO));
    send_word(ACT_BYTE, 8'h02);
    write_clock_rate(CLK_W'(1000000));
    send_word(ACT_START, 8'h00);
    send_word(ACT_BYTE, 8'(REG_FREQ_HI));
    send_word(ACT_BYTE, 8'hFF);
    send_word(ACT_BYTE, 8'hFF);
  endtask

  // byte 257 after a start loads the pointer again
  task automatic test_byte_count_wrap();
    gap_max = 2;
    send_word(ACT_START, 8'h00);
    send_word(ACT_BYTE, 8'hC8);
    repeat (255) send_word(ACT_BYTE, pick_byte());
    send_word(ACT_BYTE, 8'(REG_GREEN));
    send_word(ACT_BYTE, 8'h7F);
    send_word(ACT_BYTE, 8'h40);
  endtask

  task automatic test_random_traffic();
    int first_word;
    int next_cfg;
    int n;
    logic [CLK_W-1:0] rate;
    first_word = words_sent;
    next_cfg = words_sent;
    while (words_sent - first_word < RANDOM_WORDS) begin
      if (words_sent >= next_cfg) begin
        case ($urandom_range(6))
          0: rate = '0;
          1: rate = CLK_W'(1);
          2: rate = CLK_W'(1000000);
          3: rate = '1;
          4: rate = CLK_W'($urandom_range(300, 1));
          default: rate = CLK_W'($urandom_range(1000000, 1));
        endcase
        write_clock_rate(rate);
        case ($urandom_range(3))
          0: gap_max = 0;
          1: gap_max = 2;
          2: gap_max = 6;
          default: gap_max = 12;
        endcase
        next_cfg = words_sent + $urandom_range(300, 150);
      end
      n = $urandom_range(99);
      if (n < 70) begin
        // well-formed transfer: start, pointer, a run of register bytes with some idle ticks
        send_word(ACT_START, pick_byte());
        if ($urandom_range(9) == 0) send_word(ACT_BYTE, 8'($urandom_range(255, 7)));
        else send_word(ACT_BYTE, 8'($urandom_range(6)));
        repeat ($urandom_range(8, 1)) begin
          if ($urandom_range(5) == 0) send_word(ACT_IDLE, pick_byte());
          send_word(ACT_BYTE, pick_byte());
        end
      end else if (n < 85) begin
        repeat ($urandom_range(4, 1)) send_word(ACT_IDLE, pick_byte());
      end else begin
        send_word(2'($urandom_range(3)), pick_byte());
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_register_writes();
    test_pointer_cases();
    test_clock_rate_extremes();
    test_byte_count_wrap();
    write_clock_rate(DEFAULT_CLOCK);
    test_random_traffic();
    wait_idle();
    if (mismatches == 0) begin
      $display("feedback_register_pwm_tone_ctrl_unit_test: done, clean");
    end else begin
      $display("feedback_register_pwm_tone_ctrl_unit_test: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
src/fbpwm_pkg.sv
src/fbpwm_div.sv
src/feedback_register_pwm_tone_ctrl_unit.sv
src/fbpwm_chk.sv
verif/feedback_register_pwm_tone_ctrl_unit_test.sv
